>>> rtl/assert_macros.svh
// Assertion helpers for the polyline follower
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PCSF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define PCSF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/pcsf_pkg.sv
package pcsf_pkg;

   localparam int DefVertexDepth = 64;
   localparam int CoordW         = 32;
   localparam int FracW          = 17;
   localparam logic [FracW-1:0] FracOne = 17'h10000;

   typedef enum logic [1:0] {
      STAT_POS   = 2'd0,
      STAT_FEW   = 2'd1,
      STAT_STORE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_BLEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        step_speed;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

endpackage

>>> rtl/polyline_constant_speed_follower.sv
// An append, or a tick with too few vertices, passes RD_A and DONE, and its response
// is registered out of DONE; a tick that yields a position also passes RD_B, DIFF, a
// sum of squares, a bit-serial 34-bit square root, a 48-bit divider (cut short on a
// zero-length segment) and a two-product blend. Throughput: one request per response;
// the next request is taken at the edge that ends the response cycle.
// Reset (synchronous, active high) clears vertex count, segment and fraction;
// the vertex memory is left undefined. The receiver cannot stall: each response
// is shown for exactly one cycle with rsp_valid.
module polyline_constant_speed_follower
   import pcsf_pkg::*;
#(
   parameter int VERTEX_DEPTH = DefVertexDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
`include "assert_macros.svh"

   localparam int IdxW = $clog2(VERTEX_DEPTH);
   localparam int CntW = $clog2(VERTEX_DEPTH + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(VERTEX_DEPTH);

   // vertex memory, one read port with registered data
   logic [95:0] vmem [VERTEX_DEPTH];
   logic [95:0] rd_ff;
   logic [IdxW-1:0] rd_addr;
   logic        we;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CntW-1:0] count_ff;
   logic [IdxW-1:0] seg_ff;
   logic [FracW-1:0] frac_ff;
   logic [95:0] va_ff, vb_ff;
   logic [32:0] d_ff [3];
   logic [67:0] sum_ff;
   logic [1:0]  k_ff;
   logic [6:0]  it_ff;
   // square root: remainder / root, one bit a cycle
   logic [69:0] rem_ff;
   logic [67:0] src_ff;
   logic [33:0] root_ff;
   // divider: shift-subtract, one quotient bit a cycle
   logic [47:0] num_ff;
   logic [34:0] drem_ff;
   logic [47:0] quo_ff;
   logic signed [65:0] acc_ff;
   logic [1:0]  bsub_ff;
   rsp_type     rsp_ff;
   logic        rv_ff;
   logic        advance;

   always_ff @(posedge clock) begin
      if (we) vmem[count_ff[IdxW-1:0]] <= {req_ff.pos_x, req_ff.pos_y, req_ff.pos_z};
      rd_ff <= vmem[rd_addr];
   end

   assign we = (state_ff == ST_RD_A) && !req_ff.command && (count_ff != DepthC);
   assign rd_addr = (state_ff == ST_IDLE) ? seg_ff : seg_ff + IdxW'(1);

   function automatic logic [31:0] coord(input logic [95:0] v, input logic [1:0] k);
      logic [31:0] r;
      unique case (k)
         2'd0:    r = v[95:64];
         2'd1:    r = v[63:32];
         default: r = v[31:0];
      endcase
      return r;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_RD_A;
         ST_RD_A: begin
            if (!req_ff.command) state_in = ST_DONE;
            else if ((CntW+1)'(seg_ff) + (CntW+1)'(1) >= (CntW+1)'(count_ff))
               state_in = ST_DONE;
            else state_in = ST_RD_B;
         end
         ST_RD_B:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_SQ;
         ST_SQ:    if (k_ff == 2'd2) state_in = ST_SQRT;
         ST_SQRT:  if (it_ff == 7'd34) state_in = ST_DIV;
         ST_DIV:   if (it_ff == 7'd47 || root_ff == '0) state_in = ST_BLEND;
         ST_BLEND: if (k_ff == 2'd2 && bsub_ff == 2'd1) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff != ST_IDLE);
   end
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   logic [35:0] sq_trial;
   logic [69:0] rem_sh;
   logic [34:0] dsh;
   logic [47:0] quo_full;
   logic [16:0] nf;
   logic [67:0] sq_prod;
   logic signed [65:0] blend_sum;
   always_comb begin
      rem_sh    = {rem_ff[67:0], src_ff[67:66]};
      sq_trial  = {root_ff, 2'b01};
      dsh       = {drem_ff[33:0], num_ff[47]};
      quo_full  = quo_ff;
      nf        = (quo_full > 48'(FracOne)) ? FracOne : frac_ff + quo_full[16:0];
      advance   = (root_ff == '0) || ({1'b0, nf} >= {1'b0, FracOne}) ||
                  (quo_full >= 48'(FracOne));
      // shared multiplier: one axis squared a cycle
      sq_prod   = 68'($signed(d_ff[k_ff]) * $signed(d_ff[k_ff]));
      // second blend product, rounded half up
      blend_sum = acc_ff + 66'($signed(coord(vb_ff, k_ff)) * $signed({1'b0, frac_ff})) +
                  66'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         seg_ff   <= '0;
         frac_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= (state_ff == ST_DONE);
         if (state_ff == ST_RD_A && !req_ff.command && count_ff != DepthC)
            count_ff <= count_ff + CntW'(1);
         if (state_ff == ST_BLEND && state_in == ST_DONE) begin
            // advance segment (wrapping to the first) or update the fraction
            if (advance) begin
               frac_ff <= '0;
               if ((CntW+1)'(seg_ff) + (CntW+1)'(2) == (CntW+1)'(count_ff)) seg_ff <= '0;
               else seg_ff <= seg_ff + IdxW'(1);
            end else frac_ff <= nf;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            req_ff <= req_data;
         end
         ST_RD_A: begin
            va_ff <= rd_ff;
            rsp_ff <= '{status: (!req_ff.command) ?
                                   ((count_ff == DepthC) ? STAT_FULL : STAT_STORE) :
                                   STAT_FEW,
                        out_x: '0, out_y: '0, out_z: '0};
         end
         ST_RD_B: vb_ff <= rd_ff;
         ST_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               d_ff[k] <= 33'($signed(coord(vb_ff, 2'(k)))) -
                          33'($signed(coord(va_ff, 2'(k))));
            end
            sum_ff <= '0;
            k_ff   <= '0;
         end
         ST_SQ: begin
            sum_ff <= sum_ff + sq_prod;
            k_ff   <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            it_ff  <= '0;
            rem_ff <= '0;
            root_ff <= '0;
            if (k_ff == 2'd2) src_ff <= sum_ff + sq_prod;
         end
         ST_SQRT: begin
            if (it_ff < 7'd34) begin
               if (rem_sh >= 70'(sq_trial)) begin
                  rem_ff  <= rem_sh - 70'(sq_trial);
                  root_ff <= {root_ff[32:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[32:0], 1'b0};
               end
               src_ff <= {src_ff[65:0], 2'b00};
               it_ff  <= it_ff + 7'd1;
            end else begin
               it_ff   <= '0;
               num_ff  <= {req_ff.step_speed, 16'h0};
               drem_ff <= '0;
               quo_ff  <= '0;
            end
         end
         ST_DIV: begin
            drem_ff <= (dsh >= {1'b0, root_ff}) ? dsh - {1'b0, root_ff} : dsh;
            if (root_ff == '0) quo_ff <= '0;
            else quo_ff <= {quo_ff[46:0], dsh >= {1'b0, root_ff}};
            num_ff <= {num_ff[46:0], 1'b0};
            if (it_ff == 7'd47 || root_ff == '0) it_ff <= '0;
            else it_ff <= it_ff + 7'd1;
            k_ff   <= '0;
            bsub_ff <= '0;
         end
         ST_BLEND: begin
            // two products per axis, one per sub-step
            if (bsub_ff == 2'd0) begin
               acc_ff <= 66'($signed(coord(va_ff, k_ff)) *
                             $signed({1'b0, FracOne - frac_ff}));
               if (k_ff == 2'd0) rsp_ff.status <= STAT_POS;
               bsub_ff <= 2'd1;
            end else begin
               unique case (k_ff)
                  2'd0:    rsp_ff.out_x <= blend_sum[47:16];
                  2'd1:    rsp_ff.out_y <= blend_sum[47:16];
                  default: rsp_ff.out_z <= blend_sum[47:16];
               endcase
               bsub_ff <= 2'd0;
               k_ff <= k_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   `PCSF_ASSERT(a_rsp_after_done, rv_ff |-> $past(state_ff) == ST_DONE,
                "response without completed request")
   `PCSF_ASSERT(a_frac_below_one, frac_ff < FracOne, "fraction reached one")
   `PCSF_ASSERT(a_count_bound, count_ff <= DepthC, "vertex count beyond depth")
   `PCSF_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && !rv_ff,
                "not idle after reset")

endmodule

>>> sim/tb_polyline_constant_speed_follower.sv
module tb_polyline_constant_speed_follower;
   import pcsf_pkg::*;

   localparam int Depth      = DefVertexDepth;
   localparam int IdleLimit  = 2000;
   localparam int RandomReqs = 1030;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   int errors = 0;
   int idle_cycles = 0;
   int reqs_sent = 0;
   int ticks_valid = 0;
   int rsp_seen = 0;

   polyline_constant_speed_follower DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Scoreboard: owns a private copy of the follower state and predicts
   // one response per accepted request.
   class follower_scoreboard;
      logic [31:0] vx [Depth];
      logic [31:0] vy [Depth];
      logic [31:0] vz [Depth];
      int unsigned n_vert;
      int unsigned seg;
      logic [16:0] frac;
      rsp_type     pending [$];

      function void clear();
         n_vert = 0;
         seg    = 0;
         frac   = '0;
         pending.delete();
      endfunction

      // Round half up of from*(1-f) + to*f in Q16.16
      function logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [16:0] f);
         logic signed [63:0] p;
         p = $signed(a) * $signed({1'b0, 17'h10000 - f})
             + $signed(b) * $signed({1'b0, f});
         p = p + 64'sd32768;
         return p[47:16];
      endfunction

      function logic [33:0] root68(logic [67:0] s);
         logic [33:0] r;
         logic [33:0] c;
         r = '0;
         for (int i = 33; i >= 0; i--) begin
            c = r | (34'd1 << i);
            if ({34'd0, c} * {34'd0, c} <= s) r = c;
         end
         return r;
      endfunction

      function void note_request(req_type q);
         rsp_type     e;
         logic [32:0] d;
         logic [67:0] ssum;
         logic [33:0] len;
         logic [63:0] inc;
         logic [64:0] nf;
         logic [31:0] ca [3];
         logic [31:0] cb [3];
         bit          adv;
         e = '0;
         if (q.command == 1'b0) begin
            if (n_vert >= Depth) e.status = STAT_FULL;
            else begin
               vx[n_vert] = q.pos_x;
               vy[n_vert] = q.pos_y;
               vz[n_vert] = q.pos_z;
               n_vert++;
               e.status = STAT_STORE;
            end
         end else if (seg + 1 >= n_vert) begin
            e.status = STAT_FEW;
         end else begin
            ca = '{vx[seg], vy[seg], vz[seg]};
            cb = '{vx[seg+1], vy[seg+1], vz[seg+1]};
            ssum = '0;
            for (int k = 0; k < 3; k++) begin
               d = {cb[k][31], cb[k]} - {ca[k][31], ca[k]};
               if (d[32]) d = -d;
               ssum = ssum + {35'd0, d} * {35'd0, d};
            end
            e.status = STAT_POS;
            e.out_x  = lerp(ca[0], cb[0], frac);
            e.out_y  = lerp(ca[1], cb[1], frac);
            e.out_z  = lerp(ca[2], cb[2], frac);
            len = root68(ssum);
            if (len == 0) adv = 1'b1;
            else begin
               inc = {q.step_speed, 16'd0} / {30'd0, len};
               nf  = {48'd0, frac} + {1'b0, inc};
               adv = nf >= 65'h10000;
               if (!adv) frac = nf[16:0];
            end
            if (adv) begin
               frac = '0;
               seg  = (seg + 2 == n_vert) ? 0 : seg + 1;
            end
         end
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("response with none expected: %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
         end
         if (got.out_x !== e.out_x) begin
            $error("out_x expected %h actual %h", e.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== e.out_y) begin
            $error("out_y expected %h actual %h", e.out_y, got.out_y);
            errors++;
         end
         if (got.out_z !== e.out_z) begin
            $error("out_z expected %h actual %h", e.out_z, got.out_z);
            errors++;
         end
      endfunction
   endclass

   follower_scoreboard sb = new();

   // Sample both handshakes at the edge; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_data);
            if (req_data.command && sb.pending[$].status == STAT_POS) ticks_valid++;
         end
         if (rsp_valid) begin
            sb.check_response(rsp_data);
            rsp_seen++;
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("polyline_constant_speed_follower: mismatch");
            $finish;
         end
      end
   end

   // Hold the request until accepted; start stays high for a following request.
   task automatic send(req_type q);
      start    <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      reqs_sent++;
   endtask

   // Drop start for a gap set by n; a non-positive n leaves start as it is.
   task automatic gap(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] coord();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] speed();
      case ($urandom_range(0, 6))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(0, 32'h0008_0000);
         4:       return $urandom_range(0, 32'h0000_1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type mk_add(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type q;
      q.command    = 1'b0;
      q.pos_x      = x;
      q.pos_y      = y;
      q.pos_z      = z;
      q.step_speed = $urandom();
      return q;
   endfunction

   function automatic req_type mk_tick(logic [31:0] s);
      req_type q;
      q.command    = 1'b1;
      q.pos_x      = $urandom();
      q.pos_y      = $urandom();
      q.pos_z      = $urandom();
      q.step_speed = s;
      return q;
   endfunction

   function automatic req_type rand_req(int tick_pct);
      if ($urandom_range(1, 100) <= tick_pct) return mk_tick(speed());
      return mk_add(coord(), coord(), coord());
   endfunction

   initial begin
      int burst;
      int n;
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: too few vertices, extreme coordinates, zero-length segment,
      // slow and saturating speeds, wrap back to the first segment.
      send(mk_tick(32'h0001_0000));
      send(mk_add(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
      send(mk_tick(32'hFFFF_FFFF));
      send(mk_add(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
      send(mk_tick(32'h0000_0001));
      send(mk_tick(32'h1000_0000));
      send(mk_tick(32'h0));
      send(mk_add(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
      send(mk_add(32'h0001_0000, 32'h0002_0000, 32'h8000_0000));
      for (int i = 0; i < 8; i++) send(mk_tick(32'h0000_4000 << (i % 4)));
      send(mk_tick(32'hFFFF_FFFF));
      send(mk_tick(32'hFFFF_FFFF));
      send(mk_tick(32'hFFFF_FFFF));

      // Random: fill the store with bursts of mostly appends, then mostly ticks;
      // once full, more appends exercise the refusal.
      n = 0;
      while (n < RandomReqs) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && n < RandomReqs; i++) begin
            send(rand_req(sb.n_vert < Depth ? 35 : 85));
            n++;
         end
         if ($urandom_range(0, 3) != 0) gap($urandom_range(0, 60));
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d requests, %0d responses checked, %0d ticks gave a position",
               reqs_sent, rsp_seen, ticks_valid);
      $display("vertex store ended with %0d entries", sb.n_vert);
      if (errors == 0) $display("polyline_constant_speed_follower: match");
      else $display("polyline_constant_speed_follower: mismatch");
      $finish;
   end

endmodule
